// ===== hw/rtl/command_line_parser_defines.svh =====
// Assertion macros shared by the command line parser RTL.
// Used by command_line_parser.sv; expects clk_i and rst_ni in scope.
`ifndef COMMAND_LINE_PARSER_DEFINES_SVH
`define COMMAND_LINE_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/clp_pkg.sv =====
// Package for the command line parser: request and result types, state codes,
// character constants and the keyword table. No dependencies.
`timescale 1ns / 1ps

package clp_pkg;

  typedef struct packed {
    logic       line_start;
    logic [7:0] char_code;
  } clp_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  command_code;
    logic [3:0]  arg_index;
    logic [31:0] arg_value;
    logic        line_done;
  } clp_out_t;

  typedef struct packed {
    logic     valid;
    clp_out_t data;
  } clp_res_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_SEEK,
    PH_NAME,
    PH_ARGS
  } phase_e;

  typedef enum logic [1:0] {
    NUM_SPACE,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_e;

  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_ARG = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [2:0] CMD_NONE = 3'd0;

  localparam int DEFAULT_MAX_ARGS = 10;

  localparam logic [1:0] PREFIX_LEN = 2'd3;
  localparam logic [3:0] NAME_POS_MAX = 4'hF;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;

  localparam int NUM_KEYWORDS = 7;
  localparam int KW_MAX_LEN   = 9;

  // Keywords are left aligned and padded with spaces; the length table bounds the match.
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    "VERSION  ", "SWEEP    ", "REGISTER ", "SINGLE   ",
    "HOWAREYOU", "STOP     ", "CHECK    "
  };

  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd7, 4'd5, 4'd8, 4'd6, 4'd9, 4'd4, 4'd5
  };

  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0: ch = 8'h41;
      2'd1: ch = 8'h4D;
      2'd2: ch = 8'h53;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/clp_kw_match.sv =====
// Keyword matcher: narrows the set of live keywords by one name character
// and reports the command code of a complete match. Uses clp_pkg.
`timescale 1ns / 1ps

module clp_kw_match import clp_pkg::*; (
  input  logic [3:0]              name_pos_i,
  input  logic [7:0]              char_i,
  input  logic [NUM_KEYWORDS-1:0] alive_i,
  output logic [NUM_KEYWORDS-1:0] alive_o,
  output logic [2:0]              code_o
);

  logic [3:0]              pos_clamped;
  logic [6:0]              char_base;
  logic [NUM_KEYWORDS-1:0] hit;

  assign pos_clamped = (name_pos_i > 4'(KW_MAX_LEN - 1)) ? 4'(KW_MAX_LEN - 1) : name_pos_i;
  assign char_base   = 7'(8 * KW_MAX_LEN - 1) - {pos_clamped, 3'b000};

  for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_kw
    assign alive_o[k] = alive_i[k] && (name_pos_i < KW_LEN[k]) &&
                        (KW_TEXT[k][char_base -: 8] == char_i);
    assign hit[k]     = alive_i[k] && (KW_LEN[k] == name_pos_i);
  end

  // The first keyword in table order wins.
  always_comb begin
    code_o = CMD_NONE;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        code_o = 3'(k + 1);
      end
    end
  end

endmodule

// ===== hw/rtl/clp_parser.sv =====
// Parser core: line state registers and the per-character update that
// produces at most one result. Uses clp_pkg and clp_kw_match.
`timescale 1ns / 1ps

module clp_parser import clp_pkg::*; #(
  parameter int MAX_ARGS = DEFAULT_MAX_ARGS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  clp_in_t  in_i,
  output clp_res_t res_o
);

  phase_e                  phase_q, phase_d;
  logic [1:0]              pc_q, pc_d;
  logic [3:0]              np_q, np_d;
  logic [NUM_KEYWORDS-1:0] alive_q, alive_d;
  logic [31:0]             acc_q, acc_d;
  logic                    neg_q, neg_d;
  num_phase_e              nph_q, nph_d;
  logic                    nonempty_q, nonempty_d;
  logic [3:0]              ae_q, ae_d;

  phase_e                  cur_phase;
  logic [1:0]              cur_pc;
  logic [3:0]              cur_np;
  logic [NUM_KEYWORDS-1:0] cur_alive;
  logic [31:0]             cur_acc;
  logic                    cur_neg;
  num_phase_e              cur_nph;
  logic                    cur_nonempty;
  logic [3:0]              cur_ae;

  logic [7:0]              ch;
  logic [7:0]              digit;
  logic                    is_digit;
  logic                    is_space;
  logic                    is_end;
  logic                    is_last;
  logic                    can_emit;
  logic [31:0]             acc_next;
  logic [31:0]             arg_val;
  logic [NUM_KEYWORDS-1:0] alive_next;
  logic [2:0]              match_code;

  // A start flag restarts the line in the prefix phase with cleared line state, whatever came before.
  always_comb begin
    if (in_i.line_start) begin
      cur_phase    = PH_PREFIX;
      cur_pc       = '0;
      cur_np       = '0;
      cur_alive    = '1;
      cur_acc      = '0;
      cur_neg      = 1'b0;
      cur_nph      = NUM_SPACE;
      cur_nonempty = 1'b0;
      cur_ae       = '0;
    end else begin
      cur_phase    = phase_q;
      cur_pc       = pc_q;
      cur_np       = np_q;
      cur_alive    = alive_q;
      cur_acc      = acc_q;
      cur_neg      = neg_q;
      cur_nph      = nph_q;
      cur_nonempty = nonempty_q;
      cur_ae       = ae_q;
    end
  end

  assign ch       = in_i.char_code;
  assign digit    = ch - CH_ZERO;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign is_last  = (ch == CH_RPAREN);
  assign is_end   = (ch == CH_COMMA) || is_last;
  assign can_emit = cur_nonempty && (cur_ae < 4'(MAX_ARGS));
  assign acc_next = (cur_acc << 3) + (cur_acc << 1) + 32'(digit[3:0]);
  assign arg_val  = cur_neg ? (32'd0 - cur_acc) : cur_acc;

  clp_kw_match u_kw_match (
    .name_pos_i (cur_np),
    .char_i     (ch),
    .alive_i    (cur_alive),
    .alive_o    (alive_next),
    .code_o     (match_code)
  );

  always_comb begin
    phase_d    = cur_phase;
    pc_d       = cur_pc;
    np_d       = cur_np;
    alive_d    = cur_alive;
    acc_d      = cur_acc;
    neg_d      = cur_neg;
    nph_d      = cur_nph;
    nonempty_d = cur_nonempty;
    ae_d       = cur_ae;
    case (cur_phase)
      PH_PREFIX: begin
        if ((cur_pc < PREFIX_LEN) && (ch == prefix_char(cur_pc))) begin
          pc_d = cur_pc + 2'd1;
          if (pc_d == PREFIX_LEN) begin
            phase_d = PH_SEEK;
          end
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_SEEK: begin
        if (ch == CH_UNDERSCORE) begin
          phase_d = PH_NAME;
        end else if (ch == CH_LPAREN) begin
          phase_d    = PH_ARGS;
          acc_d      = '0;
          neg_d      = 1'b0;
          nph_d      = NUM_SPACE;
          nonempty_d = 1'b0;
        end
      end
      PH_NAME: begin
        if (ch == CH_LPAREN) begin
          phase_d    = PH_ARGS;
          acc_d      = '0;
          neg_d      = 1'b0;
          nph_d      = NUM_SPACE;
          nonempty_d = 1'b0;
        end else begin
          alive_d = alive_next;
          if (cur_np < NAME_POS_MAX) begin
            np_d = cur_np + 4'd1;
          end
        end
      end
      PH_ARGS: begin
        if (is_end) begin
          if (can_emit) begin
            ae_d = cur_ae + 4'd1;
          end
          acc_d      = '0;
          neg_d      = 1'b0;
          nph_d      = NUM_SPACE;
          nonempty_d = 1'b0;
          if (is_last) begin
            phase_d = PH_IDLE;
          end
        end else begin
          nonempty_d = 1'b1;
          case (cur_nph)
            NUM_SPACE: begin
              if (is_space) begin
                nph_d = NUM_SPACE;
              end else if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
                neg_d = (ch == CH_MINUS);
                nph_d = NUM_DIGITS;
              end else if (is_digit) begin
                acc_d = 32'(digit[3:0]);
                nph_d = NUM_DIGITS;
              end else begin
                nph_d = NUM_DONE;
              end
            end
            NUM_DIGITS: begin
              if (is_digit) begin
                acc_d = acc_next;
              end else begin
                nph_d = NUM_DONE;
              end
            end
            default: begin
              nph_d = cur_nph;
            end
          endcase
        end
      end
      default: begin
        phase_d = cur_phase;
      end
    endcase
  end

  always_comb begin
    res_o = '0;
    case (cur_phase)
      PH_PREFIX: begin
        if (!((cur_pc < PREFIX_LEN) && (ch == prefix_char(cur_pc)))) begin
          res_o.valid          = fire_i;
          res_o.data.result_kind  = KIND_CMD;
          res_o.data.command_code = CMD_NONE;
          res_o.data.line_done    = 1'b1;
        end
      end
      PH_SEEK: begin
        if (ch == CH_LPAREN) begin
          res_o.valid             = fire_i;
          res_o.data.result_kind  = KIND_CMD;
          res_o.data.command_code = CMD_NONE;
        end
      end
      PH_NAME: begin
        if (ch == CH_LPAREN) begin
          res_o.valid             = fire_i;
          res_o.data.result_kind  = KIND_CMD;
          res_o.data.command_code = match_code;
        end
      end
      PH_ARGS: begin
        if (is_end && can_emit) begin
          res_o.valid          = fire_i;
          res_o.data.result_kind = KIND_ARG;
          res_o.data.arg_index   = cur_ae;
          res_o.data.arg_value   = arg_val;
          res_o.data.line_done   = is_last;
        end else if (is_last) begin
          res_o.valid            = fire_i;
          res_o.data.result_kind = KIND_END;
          res_o.data.line_done   = 1'b1;
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      pc_q       <= '0;
      np_q       <= '0;
      alive_q    <= '1;
      acc_q      <= '0;
      neg_q      <= 1'b0;
      nph_q      <= NUM_SPACE;
      nonempty_q <= 1'b0;
      ae_q       <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      pc_q       <= pc_d;
      np_q       <= np_d;
      alive_q    <= alive_d;
      acc_q      <= acc_d;
      neg_q      <= neg_d;
      nph_q      <= nph_d;
      nonempty_q <= nonempty_d;
      ae_q       <= ae_d;
    end
  end

endmodule

// ===== hw/rtl/clp_out_reg.sv =====
// Result register of the parser: holds one result until the receiver takes it
// and derives the request-side stall. Uses clp_pkg.
`timescale 1ns / 1ps

module clp_out_reg import clp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  clp_res_t res_i,
  input  logic     out_stall_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output clp_out_t out_data_o
);

  logic     valid_q, valid_d;
  clp_out_t data_q, data_d;

  // A new request is taken only when the held result leaves in this cycle or none is held.
  assign in_stall_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (!in_stall_o) begin
      valid_d = fire_i && res_i.valid;
    end
    if (fire_i && res_i.valid) begin
      data_d = res_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/command_line_parser.sv =====
// Top level of the command line parser: parser core and result register.
// Depends on clp_pkg, clp_parser, clp_out_reg and command_line_parser_defines.svh.
//
// Usage:
//   The request channel (in_valid_i, in_stall_o, in_data_i) carries one character
//   per request, with line_start set on the first character of a line. The result
//   channel (out_valid_o, out_stall_i, out_data_o) carries command codes, parsed
//   arguments and end markers; line_done marks the last result of a line.
//   A request is taken on a rising edge with valid high and stall low.
//   A result caused by a character appears in the cycle after that character
//   is taken. Throughput: one character per cycle while the receiver does not
//   stall a held result; the argument update is one multiply-by-ten add in the
//   single stage between the line state registers and the result register.
//   Most characters cause no result; at most one result follows each character.
//   When the receiver stalls while a result is held, in_stall_o rises in the
//   same cycle and the held result stays unchanged; characters that arrive then
//   wait at the sender.
//   Reset clears the line state to idle and empties the result register; the
//   block takes requests as soon as reset is released.
`timescale 1ns / 1ps
`include "command_line_parser_defines.svh"

module command_line_parser import clp_pkg::*; #(
  parameter int MAX_ARGS = DEFAULT_MAX_ARGS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  clp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output clp_out_t out_data_o
);

  logic     fire;
  clp_res_t res;

  assign fire = in_valid_i && !in_stall_o;

  clp_parser #(
    .MAX_ARGS (MAX_ARGS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .in_i   (in_data_i),
    .res_o  (res)
  );

  clp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `CLP_ASSERT_SAME(a_stall_only_when_held, in_stall_o, out_valid_o, "stall without a held result")
  `CLP_ASSERT_NEXT(a_bad_prefix_result, fire && in_data_i.line_start && (in_data_i.char_code != prefix_char(2'd0)), out_valid_o && out_data_o.line_done && (out_data_o.result_kind == KIND_CMD) && (out_data_o.command_code == CMD_NONE), "bad first character did not end the line")
  `CLP_ASSERT_SAME(a_end_marks_done, out_valid_o && (out_data_o.result_kind == KIND_END), out_data_o.line_done, "end result without line_done")
  `CLP_ASSERT_SAME(a_non_arg_zero, out_valid_o && (out_data_o.result_kind != KIND_ARG), (out_data_o.arg_value == 32'd0) && (out_data_o.arg_index == 4'd0), "argument fields set outside an argument result")

endmodule
